// ----- rtl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// apt_pkg
// shared types, constants and option register indexes of the text folder
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int INDEX_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [15:0]           unit_t;
    typedef logic [INDEX_BITS-1:0] pos_t;

    localparam unit_t CU_ZWNJ      = 16'h200C;
    localparam unit_t CU_ZWJ       = 16'h200D;
    localparam unit_t CU_FATHATAN  = 16'h064B;
    localparam unit_t CU_SUKUN     = 16'h0652;
    localparam unit_t CU_SUP_ALEF  = 16'h0670;
    localparam unit_t CU_TATWEEL   = 16'h0640;
    localparam unit_t CU_LAM       = 16'h0644;
    localparam unit_t CU_ALEF      = 16'h0627;
    localparam unit_t CU_FA_YEH    = 16'h06CC;
    localparam unit_t CU_KEHEH     = 16'h06A9;
    localparam unit_t CU_HEH       = 16'h0647;
    localparam unit_t CU_FA_ZERO   = 16'h06F0;
    localparam unit_t CU_FA_NINE   = 16'h06F9;
    localparam unit_t CU_AR_ZERO   = 16'h0660;
    localparam unit_t CU_AR_NINE   = 16'h0669;
    localparam unit_t CU_ASCII_ZERO = 16'h0030;

    typedef enum logic [2:0] {
        CFG_STRIP_JOINERS     = 3'd0,
        CFG_STRIP_DIACRITICS  = 3'd1,
        CFG_COLLAPSE_LAM_ALEF = 3'd2,
        CFG_UNIFY_LETTERS     = 3'd3,
        CFG_UNIFY_DIGITS      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic strip_joiners;
        logic strip_diacritics;
        logic collapse_lam_alef;
        logic unify_letters;
        logic unify_digits;
    } opts_t;

    typedef struct packed {
        unit_t       unit;
        logic [15:0] idx;
        logic        has_char;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [15:0] to_src_index(input pos_t pos);
        logic [31:0] wide;
        wide = 32'(pos);
        return wide[15:0];
    endfunction

endpackage

// ----- rtl/arabic_persian_text_folder.sv -----
// ----------------------------------------------------------------------------
// arabic_persian_text_folder
// folds a stream of arabic and persian utf-16 units with one unit of lookahead
// ----------------------------------------------------------------------------
// path: an accepted item waits in the input register until the four-entry
//   result queue has room, is then folded, and its results go into the queue
// throughput: one item per cycle while the queue has room; an item with two
//   results gives them in turn through the single result port draining the queue
// reset: options all on, lam lookahead and position cleared, result queue empty
module arabic_persian_text_folder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic [15:0] source_index,
    output logic        has_char,
    output logic        last_of_text,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_data
);

    apt_pkg::opts_t   opts_reg;
    logic             in_valid_reg;
    apt_pkg::unit_t   cu_reg;
    logic             eot_reg;
    logic             lam_pending_reg, lam_pending_next;
    apt_pkg::pos_t    lam_pos_reg, lam_pos_next;
    apt_pkg::pos_t    raw_pos_reg, raw_pos_next;
    apt_pkg::push_t   push;
    apt_pkg::result_t head;
    logic             room;
    logic             fire;
    logic             in_take;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opts_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                apt_pkg::CFG_STRIP_JOINERS:     opts_reg.strip_joiners     <= cfg_data;
                apt_pkg::CFG_STRIP_DIACRITICS:  opts_reg.strip_diacritics  <= cfg_data;
                apt_pkg::CFG_COLLAPSE_LAM_ALEF: opts_reg.collapse_lam_alef <= cfg_data;
                apt_pkg::CFG_UNIFY_LETTERS:     opts_reg.unify_letters     <= cfg_data;
                apt_pkg::CFG_UNIFY_DIGITS:      opts_reg.unify_digits      <= cfg_data;
                default:                        opts_reg <= opts_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cu_reg  <= code_unit;
            eot_reg <= end_of_text;
        end
    end

    // lookahead and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lam_pending_reg <= 1'b0;
            lam_pos_reg     <= '0;
            raw_pos_reg     <= '0;
        end
        else if (fire)
        begin
            lam_pending_reg <= lam_pending_next;
            lam_pos_reg     <= lam_pos_next;
            raw_pos_reg     <= raw_pos_next;
        end
    end

    apt_fold u_fold (
        .cu               (cu_reg),
        .eot              (eot_reg),
        .opts             (opts_reg),
        .lam_pending      (lam_pending_reg),
        .lam_pos          (lam_pos_reg),
        .raw_pos          (raw_pos_reg),
        .push             (push),
        .lam_pending_next (lam_pending_next),
        .lam_pos_next     (lam_pos_next),
        .raw_pos_next     (raw_pos_next)
    );

    apt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .pop       (!out_stall),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    assign out_unit     = head.unit;
    assign source_index = head.idx;
    assign has_char     = head.has_char;
    assign last_of_text = head.last;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("stall raised with no held item");

    a_eot_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eot_reg |=> raw_pos_reg == '0 && !lam_pending_reg)
        else $error("end of text did not clear position and lookahead");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> last_of_text)
        else $error("bare marker not flagged last");

    a_eot_always_yields: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eot_reg |-> push.count != 2'd0)
        else $error("end of text item gave no result");

endmodule

// ----- rtl/apt_fold.sv -----
// ----------------------------------------------------------------------------
// apt_fold
// per-item folding: drop rules, lam-alef lookahead, letter and digit folding
// ----------------------------------------------------------------------------
module apt_fold (
    input  apt_pkg::unit_t  cu,
    input  logic            eot,
    input  apt_pkg::opts_t  opts,
    input  logic            lam_pending,
    input  apt_pkg::pos_t   lam_pos,
    input  apt_pkg::pos_t   raw_pos,
    output apt_pkg::push_t  push,
    output logic            lam_pending_next,
    output apt_pkg::pos_t   lam_pos_next,
    output apt_pkg::pos_t   raw_pos_next
);

    function automatic apt_pkg::unit_t fold_unit(input apt_pkg::unit_t cp,
                                                 input apt_pkg::opts_t o);
        apt_pkg::unit_t u;
        u = cp;
        if (o.unify_letters)
        begin
            case (cp)
                16'h064A, 16'h0649:                   u = apt_pkg::CU_FA_YEH;
                16'h0643:                             u = apt_pkg::CU_KEHEH;
                16'h0622, 16'h0623, 16'h0625, 16'h0671: u = apt_pkg::CU_ALEF;
                16'h0629, 16'h06C0:                   u = apt_pkg::CU_HEH;
                default:                              u = u;
            endcase
        end
        if (o.unify_digits)
        begin
            if (cp >= apt_pkg::CU_FA_ZERO && cp <= apt_pkg::CU_FA_NINE)
                u = cp - apt_pkg::CU_FA_ZERO + apt_pkg::CU_ASCII_ZERO;
            else if (cp >= apt_pkg::CU_AR_ZERO && cp <= apt_pkg::CU_AR_NINE)
                u = cp - apt_pkg::CU_AR_ZERO + apt_pkg::CU_ASCII_ZERO;
        end
        return u;
    endfunction

    logic [15:0]      pos16;
    logic             drop;
    apt_pkg::result_t item;

    assign pos16 = apt_pkg::to_src_index(raw_pos);

    always_comb
    begin
        push             = '0;
        lam_pending_next = lam_pending;
        lam_pos_next     = lam_pos;
        drop             = 1'b0;
        item             = '0;

        if (lam_pending && cu == apt_pkg::CU_ALEF)
        begin
            lam_pending_next = 1'b0;
            push.first       = '{unit: apt_pkg::CU_LAM, idx: pos16, has_char: 1'b1,
                                 last: 1'b0};
            push.count       = 2'd1;
        end
        else
        begin
            if (lam_pending)
            begin
                lam_pending_next = 1'b0;
                push.first       = '{unit: apt_pkg::CU_LAM,
                                     idx: apt_pkg::to_src_index(lam_pos),
                                     has_char: 1'b1, last: 1'b0};
                push.count       = 2'd1;
            end
            if (opts.strip_joiners && (cu == apt_pkg::CU_ZWNJ || cu == apt_pkg::CU_ZWJ))
                drop = 1'b1;
            if (opts.strip_diacritics &&
                ((cu >= apt_pkg::CU_FATHATAN && cu <= apt_pkg::CU_SUKUN) ||
                 cu == apt_pkg::CU_SUP_ALEF || cu == apt_pkg::CU_TATWEEL))
                drop = 1'b1;
            if (!drop)
            begin
                if (opts.collapse_lam_alef && cu == apt_pkg::CU_LAM && !eot)
                begin
                    lam_pending_next = 1'b1;
                    lam_pos_next     = raw_pos;
                end
                else
                begin
                    item = '{unit: fold_unit(cu, opts), idx: pos16, has_char: 1'b1,
                             last: 1'b0};
                    if (push.count == 2'd0)
                        push.first = item;
                    else
                        push.second = item;
                    push.count = push.count + 2'd1;
                end
            end
        end

        if (eot)
        begin
            case (push.count)
                2'd0:
                begin
                    push.first = '{unit: '0, idx: pos16, has_char: 1'b0, last: 1'b1};
                    push.count = 2'd1;
                end
                2'd1:    push.first.last  = 1'b1;
                default: push.second.last = 1'b1;
            endcase
            lam_pending_next = 1'b0;
            raw_pos_next     = '0;
        end
        else
        begin
            raw_pos_next = raw_pos + apt_pkg::pos_t'(1);
        end
    end

endmodule

// ----- rtl/apt_result_fifo.sv -----
// ----------------------------------------------------------------------------
// apt_result_fifo
// result queue taking up to two results a cycle and giving one
// ----------------------------------------------------------------------------
module apt_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  apt_pkg::push_t   push,
    input  logic             pop,
    output apt_pkg::result_t head,
    output logic             not_empty,
    output logic             room
);

    apt_pkg::result_t mem_reg [apt_pkg::FIFO_DEPTH];

    logic [apt_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [apt_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [apt_pkg::FIFO_AW:0]   fill_reg, fill_next;
    logic [apt_pkg::FIFO_AW:0]   fill_after_pop;
    logic [apt_pkg::FIFO_AW:0]   push_n;
    logic [apt_pkg::FIFO_AW-1:0] wr_ptr_plus1;
    logic                        do_pop;

    assign not_empty      = (fill_reg != '0);
    assign head           = mem_reg[rd_ptr_reg];
    assign do_pop         = pop && not_empty;
    assign fill_after_pop = fill_reg - (apt_pkg::FIFO_AW + 1)'(do_pop);
    assign room           = (fill_after_pop <= (apt_pkg::FIFO_AW + 1)'(apt_pkg::FIFO_DEPTH - 2));
    assign push_n         = push_en ? (apt_pkg::FIFO_AW + 1)'(push.count) : '0;
    assign wr_ptr_plus1   = wr_ptr_reg + apt_pkg::FIFO_AW'(1);
    assign wr_ptr_next    = wr_ptr_reg + push_n[apt_pkg::FIFO_AW-1:0];
    assign rd_ptr_next    = rd_ptr_reg + apt_pkg::FIFO_AW'(do_pop);
    assign fill_next      = fill_after_pop + push_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push_en && push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

endmodule
